// File: src/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, masked while reset is active
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/bjcl_pkg.sv
// ----------------------------------------------------------------------------
// bjcl_pkg
// Shared types and constants of the Barth-Jespersen cell limiter.
// ----------------------------------------------------------------------------
`default_nettype none

package bjcl_pkg;

	localparam int RATIO_W   = 48;
	localparam int OSUM_W    = 48;
	localparam int WSUM_W    = 64;
	localparam int QUO_W     = 63;
	localparam int MUL_DIG   = 4;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_EXT_EN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SLACK  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_JUMP   = 2'd2;

	localparam logic [RATIO_W-1:0] SLACK_RST = 48'd28147498;
	localparam logic [RATIO_W-1:0] JUMP_RST  = 48'd3;

	typedef enum logic [1:0] {
		MSEL_TOL = 2'd0,
		MSEL_THR = 2'd1,
		MSEL_FLX = 2'd2,
		MSEL_LIM = 2'd3
	} mul_sel_t;

	typedef enum logic [1:0] {
		DSEL_BND = 2'd0,
		DSEL_WGT = 2'd1,
		DSEL_LIM = 2'd2
	} div_sel_t;

	typedef struct packed {
		logic     load;
		logic     mul_start;
		mul_sel_t mul_sel;
		logic     div_start;
		div_sel_t div_sel;
		logic     lim_triv;
		logic     lim_bdiv;
		logic     acc_flux;
		logic     acc_wgt;
		logic     fin;
		logic     lim_ldiv;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		logic mul_done;
		logic div_done;
		logic bnd_div;
		logic ext_go;
		logic jump;
		logic b_zero;
		logic last;
		logic ext_en;
		logic wgt_gt;
	} sts_t;

endpackage

`default_nettype wire

// File: src/bjcl_mul.sv
// ----------------------------------------------------------------------------
// bjcl_mul
// Shared sequential multiplier, MUL_DIG bits of the second operand per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bjcl_mul
	import bjcl_pkg::*;
#(
	parameter int AW = 33,
	parameter int BW = 48
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [AW-1:0]    a,
	input  wire logic [BW-1:0]    b,
	output logic      [AW+BW-1:0] p,
	output logic                  done
);

	localparam int PW    = AW + BW;
	localparam int STEPS = (BW + MUL_DIG - 1) / MUL_DIG;
	localparam int BSW   = STEPS * MUL_DIG;
	localparam int CNT_W = $clog2(STEPS + 1);

	logic [PW-1:0]    acc_q;
	logic [PW-1:0]    a_q;
	logic [BSW-1:0]   b_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [PW-1:0]    part;

	always_comb begin
		part = '0;
		for (int k = 0; k < MUL_DIG; k++) begin
			if (b_q[k]) begin
				part = part + (a_q << k);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(STEPS);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q   <= PW'(a);
			b_q   <= BSW'(b);
		end else if (cnt_q != '0) begin
			acc_q <= acc_q + part;
			a_q   <= a_q << MUL_DIG;
			b_q   <= b_q >> MUL_DIG;
		end
	end

	assign p    = acc_q;
	assign done = done_q;

endmodule

`default_nettype wire

// File: src/bjcl_div.sv
// ----------------------------------------------------------------------------
// bjcl_div
// Shared radix-2 restoring divider with an overflow flag for quotients above QUO_W bits.
// ----------------------------------------------------------------------------
`default_nettype none

module bjcl_div
	import bjcl_pkg::*;
#(
	parameter int NW = 81,
	parameter int IW = $clog2(NW + 1)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [QUO_W-1:0] rem_init,
	input  wire logic [NW-1:0]    num,
	input  wire logic [IW-1:0]    n_iter,
	input  wire logic [QUO_W-1:0] den,
	output logic      [QUO_W-1:0] q,
	output logic                  sat,
	output logic                  done
);

	logic [QUO_W-1:0] rem_q;
	logic [QUO_W-1:0] den_q;
	logic [NW-1:0]    num_q;
	logic [QUO_W-1:0] q_q;
	logic             sat_q;
	logic [IW-1:0]    cnt_q;
	logic             done_q;
	logic [QUO_W:0]   sh;
	logic [QUO_W:0]   diff;
	logic             ge;
	logic             hi_pos;

	assign sh     = {rem_q, num_q[NW-1]};
	assign ge     = sh >= {1'b0, den_q};
	assign diff   = sh - {1'b0, den_q};
	// quotient bit at weight 2^QUO_W or above means overflow
	assign hi_pos = 32'(cnt_q) > 32'(QUO_W);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= n_iter;
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == IW'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= rem_init;
			den_q <= den;
			num_q <= num;
			q_q   <= '0;
			sat_q <= 1'b0;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? diff[QUO_W-1:0] : sh[QUO_W-1:0];
			num_q <= num_q << 1;
			q_q   <= {q_q[QUO_W-2:0], ge & ~hi_pos};
			sat_q <= sat_q | (ge & hi_pos);
		end
	end

	assign q    = q_q;
	assign sat  = sat_q;
	assign done = done_q;

endmodule

`default_nettype wire

// File: src/bjcl_dp.sv
// ----------------------------------------------------------------------------
// bjcl_dp
// Datapath: face registers, configuration, limiter state, accumulators,
// shared multiplier and divider, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bjcl_dp
	import bjcl_pkg::*;
#(
	parameter int VALUE_WIDTH = 32,
	parameter int FRAC_BITS   = 16,
	parameter int IN_W        = 224
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic [IN_W-1:0]      in_data,
	input  wire logic                 in_upwind,
	input  wire logic                 in_last,
	input  wire logic                 wr_en,
	input  wire logic [CFG_IDX_W-1:0] wr_index,
	input  wire logic [RATIO_W-1:0]   wr_data,
	input  wire cmd_t                 cmd,
	output sts_t                      sts,
	output logic      [FRAC_BITS:0]   out_lim,
	output logic                      out_scaled
);

	localparam int V    = VALUE_WIDTH;
	localparam int F    = FRAC_BITS;
	localparam int MA   = (V + 1 > F + 1) ? V + 1 : F + 1;
	localparam int PW   = MA + RATIO_W;
	localparam int CW   = MA + 2;
	localparam int NI_W = $clog2(PW + 1);
	localparam logic [F:0] LIM_ONE = {1'b1, {F{1'b0}}};

	// face registers
	logic signed [V-1:0] cv_q, d_q, fmin_q, fmax_q, cmin_q, cmax_q;
	logic [V-1:0]        flux_q;
	logic                up_q, last_q;

	// configuration
	logic               ext_en_q;
	logic [RATIO_W-1:0] slack_q, jump_q;

	// cell state
	logic [F:0]               lim_q;
	logic [OSUM_W-1:0]        oflux_q;
	logic signed [WSUM_W-1:0] wsum_q;
	logic                     stop_q;
	logic                     scaled_q;
	logic [F:0]               out_lim_q;
	logic                     out_scaled_q;

	// unit interfaces
	logic [MA-1:0]      mul_a;
	logic [RATIO_W-1:0] mul_b;
	logic [PW-1:0]      prod;
	logic               mul_done;
	logic [QUO_W-1:0]   div_rem, div_den, div_q;
	logic [PW-1:0]      div_num;
	logic [NI_W-1:0]    div_n;
	logic               div_sat, div_done;

	// face arithmetic
	logic [V-1:0]        cv_mag, d_mag;
	logic signed [V:0]   u1f, num, b_dist;
	logic [V:0]          u1f_mag, num_mag, b_mag, jsum;
	logic [MA-1:0]       tol;
	logic signed [CW-1:0] u1f_w, lo_b, hi_b;
	logic                lo_hit, hi_hit, hit, d_zero, d_pos, num_pos, num_ge, sgn_diff;
	logic                bnd_div;
	logic [F:0]          triv_r, bnd_r, fin_r;
	logic                wneg;
	logic signed [WSUM_W:0] wext, m_ext, wt;
	logic [WSUM_W-1:0]   wt_sat;
	logic [OSUM_W:0]     osum;

	assign cv_mag  = cv_q[V-1] ? -cv_q : cv_q;
	assign d_mag   = d_q[V-1] ? -d_q : d_q;
	assign u1f     = (V+1)'(cv_q) + (V+1)'(d_q);
	assign u1f_mag = u1f[V] ? -u1f : u1f;
	assign jsum    = u1f_mag + {1'b0, cv_mag};

	assign tol   = prod[PW-1:RATIO_W];
	assign u1f_w = CW'(u1f);
	assign lo_b  = CW'(fmin_q) - $signed({2'b00, tol});
	assign hi_b  = CW'(fmax_q) + $signed({2'b00, tol});
	assign lo_hit = u1f_w < lo_b;
	assign hi_hit = u1f_w > hi_b;
	assign hit    = lo_hit | hi_hit;

	assign num      = lo_hit ? (V+1)'(fmin_q) - (V+1)'(cv_q) : (V+1)'(fmax_q) - (V+1)'(cv_q);
	assign num_mag  = num[V] ? -num : num;
	assign num_pos  = !num[V] && (num != '0);
	assign d_zero   = (d_q == '0);
	assign d_pos    = !d_q[V-1] && !d_zero;
	assign sgn_diff = num[V] != d_q[V-1];
	assign num_ge   = num_mag >= {1'b0, d_mag};
	assign bnd_div  = hit && !d_zero && !sgn_diff && !num_ge;

	always_comb begin
		if (!hit) begin
			triv_r = LIM_ONE;
		end else if (d_zero) begin
			triv_r = num_pos ? LIM_ONE : '0;
		end else if (sgn_diff) begin
			triv_r = '0;
		end else begin
			triv_r = LIM_ONE;
		end
	end

	assign bnd_r = div_q[F:0];
	assign fin_r = div_q[F:0];

	// bound distance and signed weighted term
	assign b_dist = d_pos ? (V+1)'(cv_q) - (V+1)'(cmin_q) : (V+1)'(cv_q) - (V+1)'(cmax_q);
	assign b_mag  = b_dist[V] ? -b_dist : b_dist;
	assign wneg   = d_q[V-1] != b_dist[V];
	assign wext   = {wsum_q[WSUM_W-1], wsum_q};
	assign m_ext  = div_sat ? $signed({2'b00, {QUO_W{1'b1}}}) : $signed({2'b00, div_q});
	assign wt     = wneg ? wext - m_ext : wext + m_ext;
	always_comb begin
		if (wt[WSUM_W] != wt[WSUM_W-1]) begin
			wt_sat = wt[WSUM_W] ? {1'b1, {(WSUM_W-1){1'b0}}} : {1'b0, {(WSUM_W-1){1'b1}}};
		end else begin
			wt_sat = wt[WSUM_W-1:0];
		end
	end

	assign osum = {1'b0, oflux_q} + (OSUM_W+1)'(flux_q);

	// operand selection for the shared units
	always_comb begin
		case (cmd.mul_sel)
			MSEL_TOL: begin
				mul_a = MA'(cv_mag);
				mul_b = slack_q;
			end
			MSEL_THR: begin
				mul_a = MA'(jsum);
				mul_b = jump_q;
			end
			MSEL_FLX: begin
				mul_a = MA'(flux_q);
				mul_b = RATIO_W'(d_mag);
			end
			MSEL_LIM: begin
				mul_a = stop_q ? '0 : MA'(lim_q);
				mul_b = oflux_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		case (cmd.div_sel)
			DSEL_BND: begin
				div_rem = QUO_W'(num_mag);
				div_num = '0;
				div_n   = NI_W'(F);
				div_den = QUO_W'(d_mag);
			end
			DSEL_WGT: begin
				div_rem = '0;
				div_num = prod;
				div_n   = NI_W'(PW);
				div_den = QUO_W'(b_mag);
			end
			default: begin
				div_rem = '0;
				div_num = prod;
				div_n   = NI_W'(PW);
				div_den = wsum_q[QUO_W-1:0];
			end
		endcase
	end

	bjcl_mul #(
		.AW(MA),
		.BW(RATIO_W)
	) u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.mul_start),
		.a     (mul_a),
		.b     (mul_b),
		.p     (prod),
		.done  (mul_done)
	);

	bjcl_div #(
		.NW(PW)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.rem_init(div_rem),
		.num     (div_num),
		.n_iter  (div_n),
		.den     (div_den),
		.q       (div_q),
		.sat     (div_sat),
		.done    (div_done)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cv_q   <= in_data[0*V +: V];
			d_q    <= in_data[1*V +: V];
			fmin_q <= in_data[2*V +: V];
			fmax_q <= in_data[3*V +: V];
			cmin_q <= in_data[4*V +: V];
			cmax_q <= in_data[5*V +: V];
			flux_q <= in_data[6*V +: V];
			up_q   <= in_upwind;
			last_q <= in_last;
		end
		if (cmd.out_load) begin
			out_lim_q    <= lim_q;
			out_scaled_q <= scaled_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ext_en_q <= 1'b0;
			slack_q  <= SLACK_RST;
			jump_q   <= JUMP_RST;
			lim_q    <= LIM_ONE;
			oflux_q  <= '0;
			wsum_q   <= '0;
			stop_q   <= 1'b0;
			scaled_q <= 1'b0;
		end else begin
			if (wr_en) begin
				case (wr_index)
					REG_EXT_EN: ext_en_q <= wr_data[0];
					REG_SLACK:  slack_q  <= wr_data;
					REG_JUMP:   jump_q   <= wr_data;
					default: ;
				endcase
			end
			if (cmd.lim_triv && (triv_r < lim_q)) begin
				lim_q <= triv_r;
			end
			if (cmd.lim_bdiv && (bnd_r < lim_q)) begin
				lim_q <= bnd_r;
			end
			if (cmd.acc_flux) begin
				oflux_q <= osum[OSUM_W] ? '1 : osum[OSUM_W-1:0];
				if (b_mag == '0) begin
					stop_q <= 1'b1;
				end
			end
			if (cmd.acc_wgt) begin
				wsum_q <= wt_sat;
			end
			if (cmd.fin && ext_en_q && stop_q) begin
				lim_q    <= '0;
				scaled_q <= 1'b1;
			end
			if (cmd.lim_ldiv) begin
				lim_q    <= fin_r;
				scaled_q <= 1'b1;
			end
			if (cmd.out_load) begin
				lim_q    <= LIM_ONE;
				oflux_q  <= '0;
				wsum_q   <= '0;
				stop_q   <= 1'b0;
				scaled_q <= 1'b0;
			end
		end
	end

	assign sts.mul_done = mul_done;
	assign sts.div_done = div_done;
	assign sts.bnd_div  = bnd_div;
	assign sts.ext_go   = ext_en_q && up_q && !stop_q;
	assign sts.jump     = MA'(d_mag) > tol;
	assign sts.b_zero   = (b_mag == '0);
	assign sts.last     = last_q;
	assign sts.ext_en   = ext_en_q;
	assign sts.wgt_gt   = wsum_q > $signed({{(WSUM_W-OSUM_W){1'b0}}, oflux_q});

	assign out_lim    = out_lim_q;
	assign out_scaled = out_scaled_q;

endmodule

`default_nettype wire

// File: src/bjcl_ctrl.sv
// ----------------------------------------------------------------------------
// bjcl_ctrl
// Controller: sequences bound check and extension per face, and final scaling per cell.
// ----------------------------------------------------------------------------
`default_nettype none

module bjcl_ctrl
	import bjcl_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic      s_tready,
	output logic      m_tvalid,
	input  wire logic m_tready,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	typedef enum logic [13:0] {
		ST_IDLE   = 14'h0001,
		ST_TOL_S  = 14'h0002,
		ST_TOL_W  = 14'h0004,
		ST_BCHK   = 14'h0008,
		ST_BDIV_W = 14'h0010,
		ST_EXT    = 14'h0020,
		ST_THR_W  = 14'h0040,
		ST_JCHK   = 14'h0080,
		ST_FMUL_W = 14'h0100,
		ST_WDIV_W = 14'h0200,
		ST_FIN    = 14'h0400,
		ST_LMUL_W = 14'h0800,
		ST_LDIV_W = 14'h1000,
		ST_OUT    = 14'h2000
	} state_t;

	state_t state_q, state_nxt;
	logic   m_tvalid_q;
	state_t after_face;

	assign after_face = sts.last ? ST_FIN : ST_IDLE;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load  = 1'b1;
					state_nxt = ST_TOL_S;
				end
			end
			ST_TOL_S: begin
				cmd.mul_start = 1'b1;
				cmd.mul_sel   = MSEL_TOL;
				state_nxt     = ST_TOL_W;
			end
			ST_TOL_W: begin
				if (sts.mul_done) begin
					state_nxt = ST_BCHK;
				end
			end
			ST_BCHK: begin
				if (sts.bnd_div) begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = DSEL_BND;
					state_nxt     = ST_BDIV_W;
				end else begin
					cmd.lim_triv = 1'b1;
					state_nxt    = ST_EXT;
				end
			end
			ST_BDIV_W: begin
				if (sts.div_done) begin
					cmd.lim_bdiv = 1'b1;
					state_nxt    = ST_EXT;
				end
			end
			ST_EXT: begin
				if (sts.ext_go) begin
					cmd.mul_start = 1'b1;
					cmd.mul_sel   = MSEL_THR;
					state_nxt     = ST_THR_W;
				end else begin
					state_nxt = after_face;
				end
			end
			ST_THR_W: begin
				if (sts.mul_done) begin
					state_nxt = ST_JCHK;
				end
			end
			ST_JCHK: begin
				if (sts.jump) begin
					cmd.acc_flux = 1'b1;
					if (sts.b_zero) begin
						state_nxt = after_face;
					end else begin
						cmd.mul_start = 1'b1;
						cmd.mul_sel   = MSEL_FLX;
						state_nxt     = ST_FMUL_W;
					end
				end else begin
					state_nxt = after_face;
				end
			end
			ST_FMUL_W: begin
				if (sts.mul_done) begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = DSEL_WGT;
					state_nxt     = ST_WDIV_W;
				end
			end
			ST_WDIV_W: begin
				if (sts.div_done) begin
					cmd.acc_wgt = 1'b1;
					state_nxt   = after_face;
				end
			end
			ST_FIN: begin
				cmd.fin = 1'b1;
				if (sts.ext_en && sts.wgt_gt) begin
					cmd.mul_start = 1'b1;
					cmd.mul_sel   = MSEL_LIM;
					state_nxt     = ST_LMUL_W;
				end else begin
					state_nxt = ST_OUT;
				end
			end
			ST_LMUL_W: begin
				if (sts.mul_done) begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = DSEL_LIM;
					state_nxt     = ST_LDIV_W;
				end
			end
			ST_LDIV_W: begin
				if (sts.div_done) begin
					cmd.lim_ldiv = 1'b1;
					state_nxt    = ST_OUT;
				end
			end
			ST_OUT: begin
				// wait until the result register is free
				if (!m_tvalid_q || m_tready) begin
					cmd.out_load = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;

endmodule

`default_nettype wire

// File: src/barth_jespersen_cell_limiter.sv
// A face with no bound divide and no extension work takes the least time; a limited face adds
// a bound divide. An upwind face, with extension on and not stopped, adds a threshold multiply;
// with a jump and a nonzero bound distance it also adds a flux multiply and one wide divide.
// The last face adds the final step, plus a multiply and a wide divide when scaling,
// and waits while the result register is full. Throughput: one face at a time.
// Reset clears the running limiter to 1.0, the sums and flags, and loads register reset values.
// ----------------------------------------------------------------------------
// barth_jespersen_cell_limiter
// Per-face Barth-Jespersen limiter with optional outflux extension, one
// result per cell at the face marked last.
// ----------------------------------------------------------------------------
`default_nettype none

module barth_jespersen_cell_limiter
	import bjcl_pkg::*;
#(
	parameter int VALUE_WIDTH = 32,
	parameter int FRAC_BITS   = 16
) (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    s_tvalid,
	output logic                                         s_tready,
	// cell_value, face_delta, face_min, face_max, cell_min, cell_max, flux_magnitude
	input  wire logic [((7*VALUE_WIDTH+7)/8)*8-1:0]      s_tdata,
	// is_upwind
	input  wire logic                                    s_tuser,
	input  wire logic                                    s_tlast,
	output logic                                         m_tvalid,
	input  wire logic                                    m_tready,
	// limiter_value
	output logic      [((FRAC_BITS+1+7)/8)*8-1:0]        m_tdata,
	// extension_scaled
	output logic                                         m_tuser,
	input  wire logic                                    wr_en,
	input  wire logic [CFG_IDX_W-1:0]                    wr_index,
	input  wire logic [RATIO_W-1:0]                      wr_data
);

	localparam int IN_W  = ((7*VALUE_WIDTH+7)/8)*8;
	localparam int OUT_W = ((FRAC_BITS+1+7)/8)*8;

	cmd_t             cmd;
	sts_t             sts;
	logic [FRAC_BITS:0] out_lim;

	bjcl_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	bjcl_dp #(
		.VALUE_WIDTH(VALUE_WIDTH),
		.FRAC_BITS  (FRAC_BITS),
		.IN_W       (IN_W)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (s_tdata),
		.in_upwind (s_tuser),
		.in_last   (s_tlast),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_lim   (out_lim),
		.out_scaled(m_tuser)
	);

	assign m_tdata = OUT_W'(out_lim);

endmodule

`default_nettype wire

// File: src/bjcl_checker.sv
// ----------------------------------------------------------------------------
// bjcl_checker
// Port-level checks of the cell limiter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module bjcl_checker #(
	parameter int VALUE_WIDTH = 32,
	parameter int FRAC_BITS   = 16
) (
	input wire logic                               clk,
	input wire logic                               arst_n,
	input wire logic                               s_tvalid,
	input wire logic                               s_tready,
	input wire logic                               m_tvalid,
	input wire logic                               m_tready,
	input wire logic [((FRAC_BITS+1+7)/8)*8-1:0]   m_tdata,
	input wire logic                               m_tuser
);

	localparam int OUT_W = ((FRAC_BITS+1+7)/8)*8;
	localparam logic [OUT_W-1:0] LIM_ONE = OUT_W'(1) << FRAC_BITS;

	`ASSERT_CLK(a_out_hold, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid, "result dropped while stalled")
	`ASSERT_CLK(a_out_stable, clk, arst_n, m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")
	`ASSERT_CLK(a_lim_range, clk, arst_n, m_tvalid |-> m_tdata <= LIM_ONE, "limiter above one")
	`ASSERT_CLK(a_one_face, clk, arst_n, s_tvalid && s_tready |=> !s_tready, "second face taken during face processing")

endmodule

bind barth_jespersen_cell_limiter bjcl_checker #(
	.VALUE_WIDTH(VALUE_WIDTH),
	.FRAC_BITS  (FRAC_BITS)
) u_bjcl_checker (.*);

`default_nettype wire

// File: verif/barth_jespersen_cell_limiter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// barth_jespersen_cell_limiter_tb
// Streams face transactions into the cell limiter, under several register settings,
// and checks each cell result against a bit-accurate predictor or a directed table entry.
// ----------------------------------------------------------------------------
`default_nettype none

module barth_jespersen_cell_limiter_tb;
	import bjcl_pkg::*;

	localparam int VW = 32;
	localparam int FB = 16;
	localparam int CLK_LIMIT = 4000000;
	localparam int SETTLE = 400;
	localparam int ITEM_GOAL = 1550;
	localparam bit [16:0] LIM_ONE = 17'd65536;
	localparam bit [47:0] R48_MAX = 48'hffff_ffff_ffff;
	localparam longint W_MAX = 64'sh7fff_ffff_ffff_ffff;
	localparam longint W_MIN = -64'sh7fff_ffff_ffff_ffff - 1;
	localparam bit signed [31:0] V_MAX = 32'sh7fff_ffff;
	localparam bit signed [31:0] V_MIN = 32'sh8000_0000;

	typedef struct packed {
		bit signed [31:0] cv;
		bit signed [31:0] delta;
		bit signed [31:0] fmin;
		bit signed [31:0] fmax;
		bit signed [31:0] cmin;
		bit signed [31:0] cmax;
		bit               upwind;
		bit        [31:0] flux;
		bit               last;
	} face_t;

	typedef struct packed {
		bit        ext;
		face_t     f;
		bit        typed;
		bit [16:0] lim;
		bit        scaled;
	} dir_row_t;

	typedef struct packed {
		bit [16:0] lim;
		bit        scaled;
	} cell_res_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [223:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic        m_tuser;
	logic        wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] wr_index = '0;
	logic [RATIO_W-1:0]   wr_data = '0;

	barth_jespersen_cell_limiter dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
	);

	always #5 clk = ~clk;

	// limiter state mirror
	bit        ext_en;
	bit [47:0] slack_ratio;
	bit [47:0] jump_ratio;
	bit [16:0] run_lim;
	bit [47:0] flux_sum;
	longint    wflux_sum;
	bit        ext_stop;

	cell_res_t expected_cells[$];
	int        fails = 0;
	int        cyc = 0;
	int        n_items = 0;
	bit        ready_quiet = 1'b0;

	dir_row_t dir_tab[14] = '{
		// reset settings: no limiting, ratio of one half, opposite signs
		'{1'b0, '{32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 1'b0, 32'd0, 1'b1},
			1'b1, 17'd65536, 1'b0},
		'{1'b0, '{32'sd0, 32'sd1000, -32'sd500, 32'sd500, 32'sd0, 32'sd0, 1'b0, 32'd0, 1'b1},
			1'b1, 17'd32768, 1'b0},
		'{1'b0, '{32'sd0, 32'sd100, -32'sd100, -32'sd100, 32'sd0, 32'sd0, 1'b0, 32'd0, 1'b1},
			1'b1, 17'd0, 1'b0},
		// zero delta with the cell outside its bounds
		'{1'b0, '{32'sd1000, 32'sd0, 32'sd2000, 32'sd3000, 32'sd0, 32'sd0, 1'b0, 32'd0, 1'b1},
			1'b1, 17'd65536, 1'b0},
		'{1'b0, '{V_MIN, V_MIN, V_MAX, V_MIN, V_MIN, V_MAX, 1'b1, 32'hffff_ffff, 1'b0},
			1'b0, 17'd0, 1'b0},
		'{1'b0, '{V_MAX, V_MAX, V_MIN, V_MAX, V_MAX, V_MIN, 1'b1, 32'hffff_ffff, 1'b1},
			1'b0, 17'd0, 1'b0},
		'{1'b0, '{32'sd500, -32'sd900, 32'sd100, 32'sd600, 32'sd0, 32'sd0, 1'b0, 32'd7, 1'b0},
			1'b0, 17'd0, 1'b0},
		'{1'b0, '{32'sd500, 32'sd300, 32'sd100, 32'sd600, 32'sd0, 32'sd0, 1'b1, 32'd7, 1'b1},
			1'b0, 17'd0, 1'b0},
		// extension on: zero bound distance, positive and negative jumps
		'{1'b1, '{32'sd100, 32'sd50, -32'sd1000, 32'sd1000, 32'sd100, 32'sd0, 1'b1, 32'd65536,
			1'b1}, 1'b1, 17'd0, 1'b1},
		'{1'b1, '{32'sd100, 32'sd50, -32'sd1000, 32'sd1000, 32'sd90, 32'sd0, 1'b1, 32'd65536,
			1'b1}, 1'b1, 17'd13107, 1'b1},
		'{1'b1, '{32'sd0, -32'sd200, -32'sd1000, 32'sd1000, 32'sd0, 32'sd100, 1'b1, 32'd1000,
			1'b1}, 1'b1, 17'd32768, 1'b1},
		'{1'b1, '{32'sd0, 32'sd100, -32'sd1000, 32'sd1000, 32'sd100, 32'sd0, 1'b1, 32'd1000,
			1'b0}, 1'b0, 17'd0, 1'b0},
		'{1'b1, '{32'sd0, 32'sd100, -32'sd1000, 32'sd1000, -32'sd5, 32'sd0, 1'b0, 32'd1000,
			1'b1}, 1'b0, 17'd0, 1'b0},
		'{1'b1, '{V_MIN, V_MAX, V_MIN, V_MAX, V_MAX, V_MIN, 1'b1, 32'hffff_ffff, 1'b1},
			1'b0, 17'd0, 1'b0}
	};

	function automatic bit [63:0] abs64(longint v);
		return v < 0 ? 64'(-v) : 64'(v);
	endfunction

	function automatic bit [63:0] mul_frac48(bit [63:0] a, bit [47:0] r);
		bit [127:0] p;
		p = 128'(a) * 128'(r);
		return p[111:48];
	endfunction

	// truncating divide, saturated to 2^63 - 1
	function automatic bit [63:0] sat_div(bit [127:0] num, bit [63:0] den);
		bit [127:0] q;
		q = num / 128'(den);
		return (q > 128'(W_MAX)) ? 64'(W_MAX) : q[63:0];
	endfunction

	function automatic bit [16:0] bound_ratio(longint num, longint den);
		if (den == 0)
			return num > 0 ? LIM_ONE : 17'd0;
		if ((num < 0) != (den < 0))
			return 17'd0;
		if (abs64(num) >= abs64(den))
			return LIM_ONE;
		return 17'((128'(abs64(num)) << FB) / 128'(abs64(den)));
	endfunction

	function automatic void clear_cell();
		run_lim = LIM_ONE;
		flux_sum = '0;
		wflux_sum = 0;
		ext_stop = 1'b0;
	endfunction

	// advance the limiter by one face; returns 1 when a cell result is due
	function automatic bit limit_face(face_t f, output cell_res_t res);
		longint cv, d, u1f, tol, b;
		bit [16:0] r;
		bit [48:0] fs;
		bit [63:0] m;
		logic signed [65:0] t;
		cv = f.cv;
		d = f.delta;
		u1f = cv + d;
		tol = longint'(mul_frac48(abs64(cv), slack_ratio));
		r = LIM_ONE;
		res = '0;
		if (u1f < longint'(f.fmin) - tol)
			r = bound_ratio(longint'(f.fmin) - cv, d);
		else if (u1f > longint'(f.fmax) + tol)
			r = bound_ratio(longint'(f.fmax) - cv, d);
		if (r < run_lim)
			run_lim = r;
		if (ext_en && f.upwind && !ext_stop &&
				abs64(d) > mul_frac48(abs64(u1f) + abs64(cv), jump_ratio)) begin
			b = (d > 0) ? cv - longint'(f.cmin) : cv - longint'(f.cmax);
			fs = 49'(flux_sum) + 49'(f.flux);
			flux_sum = fs[48] ? R48_MAX : fs[47:0];
			if (b == 0) begin
				ext_stop = 1'b1;
			end else begin
				m = sat_div(128'(f.flux) * 128'(abs64(d)), abs64(b));
				if ((d < 0) != (b < 0))
					t = 66'(wflux_sum) - $signed({2'b00, m});
				else
					t = 66'(wflux_sum) + $signed({2'b00, m});
				if (t > 66'(W_MAX))
					wflux_sum = W_MAX;
				else if (t < 66'(W_MIN))
					wflux_sum = W_MIN;
				else
					wflux_sum = longint'(t[63:0]);
			end
		end
		if (!f.last)
			return 1'b0;
		if (ext_en) begin
			if (ext_stop) begin
				run_lim = '0;
				res.scaled = 1'b1;
			end
			if (wflux_sum > longint'({16'b0, flux_sum})) begin
				run_lim = 17'(sat_div(128'(run_lim) * 128'(flux_sum), 64'(wflux_sum)));
				res.scaled = 1'b1;
			end
		end
		res.lim = run_lim;
		clear_cell();
		return 1'b1;
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cyc);
		fails++;
	endtask

	// one face transaction; the face's result, if any, is queued on acceptance
	task automatic send_face(face_t f, bit typed, cell_res_t typed_res);
		int g;
		cell_res_t res;
		g = gap_len();
		if (g > 0) begin
			s_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		s_tdata <= {f.flux, f.cmax, f.cmin, f.fmax, f.fmin, f.delta, f.cv};
		s_tuser <= f.upwind;
		s_tlast <= f.last;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		n_items++;
		if (limit_face(f, res))
			expected_cells.insert(expected_cells.size(), typed ? typed_res : res);
	endtask

	// registers change only with the block drained
	task automatic write_regs(bit e, bit [47:0] s, bit [47:0] j);
		s_tvalid <= 1'b0;
		while (expected_cells.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		wr_en <= 1'b1;
		wr_index <= REG_EXT_EN;
		wr_data <= 48'(e);
		@(posedge clk);
		wr_index <= REG_SLACK;
		wr_data <= s;
		@(posedge clk);
		wr_index <= REG_JUMP;
		wr_data <= j;
		@(posedge clk);
		wr_en <= 1'b0;
		ext_en = e;
		slack_ratio = s;
		jump_ratio = j;
	endtask

	function automatic bit signed [31:0] clamp32(longint v);
		if (v > longint'(V_MAX))
			return V_MAX;
		if (v < longint'(V_MIN))
			return V_MIN;
		return 32'(v);
	endfunction

	function automatic longint spread();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 16);
			1: return $urandom_range(0, 4096);
			2: return $urandom_range(0, 1 << 20);
			default: return $urandom;
		endcase
	endfunction

	function automatic face_t random_face(bit signed [31:0] cv, bit last);
		face_t f;
		longint sd;
		f.cv = cv;
		if ($urandom_range(0, 9) == 0) begin
			// noise: every field unconstrained
			{f.delta, f.fmin, f.fmax} = {$urandom, $urandom, $urandom};
			{f.cmin, f.cmax, f.flux} = {$urandom, $urandom, $urandom};
		end else begin
			sd = spread();
			f.delta = clamp32($urandom_range(0, 1) ? sd : -sd);
			f.fmin = clamp32(longint'(cv) - spread());
			f.fmax = clamp32(longint'(cv) + spread());
			f.cmin = ($urandom_range(0, 7) == 0) ? cv : clamp32(longint'(cv) - spread());
			f.cmax = ($urandom_range(0, 7) == 0) ? cv : clamp32(longint'(cv) + spread());
			if ($urandom_range(0, 9) == 0)
				{f.cmin, f.cmax} = {f.cmax, f.cmin};
			f.flux = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 1 << 20);
		end
		f.upwind = $urandom_range(0, 9) < 6;
		f.last = last;
		return f;
	endfunction

	function automatic bit [47:0] pick_ratio(bit jump_kind);
		case ($urandom_range(0, 4))
			0: return '0;
			1: return R48_MAX;
			2: return jump_kind ? 48'(JUMP_RST) : 48'(SLACK_RST);
			3: return 48'($urandom_range(0, 1 << 30));
			default: return {$urandom, 16'($urandom)};
		endcase
	endfunction

	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc > CLK_LIMIT) begin
			$display("barth_jespersen_cell_limiter_tb failed");
			$finish;
		end
	end

	// result side: check, then pick the next tready
	always @(posedge clk) begin
		cell_res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_cells.size() == 0) begin
				report_mismatch("unexpected transaction, limiter", m_tdata[16:0], -1);
			end else begin
				want = expected_cells.pop_front();
				if (m_tdata[16:0] !== want.lim)
					report_mismatch("limiter_value", m_tdata[16:0], want.lim);
				if (m_tuser !== want.scaled)
					report_mismatch("extension_scaled", m_tuser, want.scaled);
			end
		end
		if (!arst_n)
			m_tready <= 1'b0;
		else if (ready_quiet)
			m_tready <= 1'b1;
		else
			m_tready <= ($urandom_range(0, 99) < 65) ||
				(!m_tready && $urandom_range(0, 99) < 30);
	end

	initial begin
		cell_res_t r;
		bit signed [31:0] cv;
		int nf, phase_end;
		ext_en = 1'b0;
		slack_ratio = SLACK_RST;
		jump_ratio = JUMP_RST;
		clear_cell();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i]) begin
			if (dir_tab[i].ext != ext_en)
				write_regs(dir_tab[i].ext, SLACK_RST, JUMP_RST);
			r.lim = dir_tab[i].lim;
			r.scaled = dir_tab[i].scaled;
			send_face(dir_tab[i].f, dir_tab[i].typed, r);
		end

		// extremes first, then random settings per phase
		write_regs(1'b1, '0, '0);
		for (int ph = 0; n_items < ITEM_GOAL; ph++) begin
			if (ph == 1)
				write_regs(1'b1, R48_MAX, R48_MAX);
			else if (ph == 2)
				write_regs(1'b0, R48_MAX, '0);
			else if (ph > 2)
				write_regs($urandom_range(0, 9) < 7, pick_ratio(1'b0), pick_ratio(1'b1));
			ready_quiet = ($urandom_range(0, 4) == 0);
			phase_end = n_items + $urandom_range(40, 120);
			while (n_items < phase_end) begin
				cv = ($urandom_range(0, 3) == 0) ? $urandom :
					32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
				nf = $urandom_range(1, 6);
				for (int k = 0; k < nf; k++)
					send_face(random_face(cv, k == nf - 1), 1'b0, '0);
			end
		end
		s_tvalid <= 1'b0;

		while (expected_cells.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (fails == 0)
			$display("barth_jespersen_cell_limiter_tb passed");
		else
			$display("barth_jespersen_cell_limiter_tb failed");
		$finish;
	end

endmodule

`default_nettype wire

// File: sim.f
+incdir+src
src/bjcl_pkg.sv
src/bjcl_mul.sv
src/bjcl_div.sv
src/bjcl_dp.sv
src/bjcl_ctrl.sv
src/barth_jespersen_cell_limiter.sv
src/bjcl_checker.sv
verif/barth_jespersen_cell_limiter_tb.sv
